// ===== hw/rtl/hpt_pkg.sv =====
`timescale 1ns / 1ps
package hpt_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int unsigned KEY_W   = 52;
  localparam int unsigned ASID_W  = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OC_W    = 3;
  localparam int unsigned ENT_W   = KEY_W + ASID_W + DATA_W;
  localparam int unsigned LFSR_W  = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned MODE_W     = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCRAMBLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 1'b1;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(TABLE_ENTRIES);

  // Hash modes.
  localparam logic [MODE_W-1:0] MODE_KEY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASID = 2'd1;

  // Fold of index-wide digits over the key, sized for 64 bits.
  localparam int unsigned FOLD_CNT = (64 + IDX_W - 1) / IDX_W;
  localparam int unsigned FOLD_W   = FOLD_CNT * IDX_W;

  // Victim LFSR.
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'hACE12468;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h80200003;

  // Slot status codes.
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_VALID = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  // Outcome codes.
  localparam logic [OC_W-1:0] OC_HIT      = 3'd0;
  localparam logic [OC_W-1:0] OC_INSERTED = 3'd1;
  localparam logic [OC_W-1:0] OC_REPLACED = 3'd2;
  localparam logic [OC_W-1:0] OC_REPFAIL  = 3'd3;
  localparam logic [OC_W-1:0] OC_ERASED   = 3'd4;
  localparam logic [OC_W-1:0] OC_NOTFOUND = 3'd5;
  localparam logic [OC_W-1:0] OC_FULL     = 3'd6;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_ERASE  = 1'b1;

  // Slot address selection.
  typedef enum logic [2:0] {
    SEL_S,
    SEL_FREE,
    SEL_HOME,
    SEL_VICT,
    SEL_ZERO
  } slot_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            clr_we;
    logic            load;
    logic            step;
    logic            st_we;
    logic [1:0]      st_val;
    slot_sel_e       wsel;
    logic            ent_we;
    logic            live_inc;
    logic            live_dec;
    logic            div_start;
    logic            vict_rd;
    logic            res_we;
    logic [OC_W-1:0] res_code;
    slot_sel_e       res_sel;
    logic            res_data;
    logic            out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] rd_stat;
    logic       match;
    logic       probes_max;
    logic       probes_zero;
    logic       op;
    logic       live_lt;
    logic       free_found;
    logic       clr_last;
    logic       div_done;
    logic       out_free;
  } sts_t;

  // Home slot of a key.
  function automatic logic [IDX_W-1:0] home_slot(input logic [MODE_W-1:0] mode,
                                                 input logic [KEY_W-1:0]  key,
                                                 input logic [ASID_W-1:0] asid);
    logic [FOLD_W-1:0] ext;
    logic [IDX_W-1:0]  acc;
    logic [KEY_W-1:0]  mix;
    ext = FOLD_W'(key);
    acc = '0;
    mix = key ^ KEY_W'(asid);
    for (int i = 0; i < FOLD_CNT; i++) begin
      acc = acc ^ ext[i*IDX_W +: IDX_W];
    end
    if (mode == MODE_KEY) begin
      return key[IDX_W-1:0];
    end else if (mode == MODE_ASID) begin
      return mix[IDX_W-1:0];
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/hpt_req_if.sv =====
`timescale 1ns / 1ps
interface hpt_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [hpt_pkg::KEY_W-1:0]    page_key;
  logic [hpt_pkg::ASID_W-1:0]   asid;
  logic signed [hpt_pkg::DATA_W-1:0] fill_data;

  modport source (output valid, operation, page_key, asid, fill_data, input ready);
  modport sink (input valid, operation, page_key, asid, fill_data, output ready);
endinterface

// ===== hw/rtl/hpt_rsp_if.sv =====
`timescale 1ns / 1ps
interface hpt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [hpt_pkg::OC_W-1:0]          outcome;
  logic signed [hpt_pkg::DATA_W-1:0] hit_data;
  logic [hpt_pkg::IDX_W-1:0]         slot_index;
  logic [hpt_pkg::CNT_W-1:0]         probe_count;

  modport source (output valid, outcome, hit_data, slot_index, probe_count, input ready);
  modport sink (input valid, outcome, hit_data, slot_index, probe_count, output ready);
endinterface

// ===== hw/rtl/hpt_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module hpt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hpt_pkg::LFSR_W-1:0]   dividend_i,
  input  logic [hpt_pkg::CNT_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [hpt_pkg::CNT_W-1:0]    rem_o
);

  localparam int unsigned STEP_W = $clog2(hpt_pkg::LFSR_W);

  logic [hpt_pkg::LFSR_W-1:0] dvd_q;
  logic [hpt_pkg::CNT_W-1:0]  dvs_q;
  logic [hpt_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]          cnt_q;
  logic                       busy_q, done_q;
  logic [hpt_pkg::CNT_W:0]    trial;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, dvd_q[hpt_pkg::LFSR_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = hpt_pkg::CNT_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[hpt_pkg::CNT_W-1:0];
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(hpt_pkg::LFSR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[hpt_pkg::LFSR_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/hpt_dp.sv =====
`timescale 1ns / 1ps
// Datapath: slot memories, probe pointer, counters, LFSR and result registers.
module hpt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hpt_pkg::cmd_t        cmd_i,
  output hpt_pkg::sts_t        sts_o,
  input  logic                 cfg_we_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hpt_req_if.sink              req_i,
  hpt_rsp_if.source            rsp_o
);

  localparam int unsigned N = hpt_pkg::TABLE_ENTRIES;
  localparam int unsigned IW = hpt_pkg::IDX_W;
  localparam int unsigned CW = hpt_pkg::CNT_W;

  logic [1:0]                 stat_mem [N];
  logic [hpt_pkg::ENT_W-1:0]  ent_mem [N];
  logic [1:0]                 stat_rd_q;
  logic [hpt_pkg::ENT_W-1:0]  ent_rd_q;

  logic [hpt_pkg::MODE_W-1:0] mode_q;
  logic [CW-1:0]              limit_q;
  logic [CW-1:0]              live_q;
  logic [hpt_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [IW-1:0]              clr_q;

  logic                       op_q;
  logic [hpt_pkg::KEY_W-1:0]  key_q;
  logic [hpt_pkg::ASID_W-1:0] asid_q;
  logic [hpt_pkg::DATA_W-1:0] data_q;
  logic [IW-1:0]              home_q, s_q, free_q, vict_q;
  logic [CW-1:0]              probes_q;
  logic                       free_found_q;

  logic [hpt_pkg::OC_W-1:0]   res_oc_q;
  logic [hpt_pkg::DATA_W-1:0] res_data_q;
  logic [IW-1:0]              res_slot_q;
  logic [CW-1:0]              res_probes_q;
  logic                       out_valid_q;

  logic                       div_done;
  logic [CW-1:0]              div_rem;
  logic [IW-1:0]              rd_addr, wr_addr, st_addr, res_slot;
  logic [1:0]                 st_wval;

  function automatic logic [IW-1:0] pick(input hpt_pkg::slot_sel_e sel,
                                         input logic [IW-1:0] s, input logic [IW-1:0] f,
                                         input logic [IW-1:0] h, input logic [IW-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    case (sel)
      hpt_pkg::SEL_S:    r = s;
      hpt_pkg::SEL_FREE: r = f;
      hpt_pkg::SEL_HOME: r = h;
      hpt_pkg::SEL_VICT: r = v;
      default:           r = '0;
    endcase
    return r;
  endfunction

  // Address selection for the memories.
  always_comb begin
    rd_addr  = cmd_i.vict_rd ? vict_q : s_q;
    wr_addr  = pick(cmd_i.wsel, s_q, free_q, home_q, vict_q);
    st_addr  = cmd_i.clr_we ? clr_q : wr_addr;
    st_wval  = cmd_i.clr_we ? hpt_pkg::ST_EMPTY : cmd_i.st_val;
    res_slot = pick(cmd_i.res_sel, s_q, free_q, home_q, vict_q);
  end

  // Slot memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we || cmd_i.st_we) begin
      stat_mem[st_addr] <= st_wval;
    end
    if (cmd_i.ent_we) begin
      ent_mem[wr_addr] <= {key_q, asid_q, data_q};
    end
    stat_rd_q <= stat_mem[rd_addr];
    ent_rd_q  <= ent_mem[rd_addr];
  end

  // Next value of the Galois LFSR.
  always_comb begin
    if (lfsr_q[0]) begin
      lfsr_d = (lfsr_q >> 1) ^ hpt_pkg::LFSR_TAPS;
    end else begin
      lfsr_d = lfsr_q >> 1;
    end
  end

  // Control state: configuration, counters, LFSR, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= hpt_pkg::MODE_KEY;
      limit_q      <= hpt_pkg::LIMIT_RESET;
      live_q       <= '0;
      lfsr_q       <= hpt_pkg::LFSR_SEED;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == hpt_pkg::REG_SCRAMBLE) begin
        mode_q <= cfg_data_i[hpt_pkg::MODE_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == hpt_pkg::REG_LIMIT) begin
        limit_q <= cfg_data_i[CW-1:0];
      end
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.live_inc) begin
        live_q <= live_q + 1'b1;
      end else if (cmd_i.live_dec && live_q != '0) begin
        live_q <= live_q - 1'b1;
      end
      if (cmd_i.div_start) begin
        lfsr_q <= lfsr_d;
      end
      if (cmd_i.load) begin
        free_found_q <= 1'b0;
      end else if (cmd_i.step && stat_rd_q == hpt_pkg::ST_TOMB) begin
        free_found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item registers and probe pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= req_i.operation;
      key_q    <= req_i.page_key;
      asid_q   <= req_i.asid;
      data_q   <= req_i.fill_data;
      home_q   <= hpt_pkg::home_slot(mode_q, req_i.page_key, req_i.asid);
      s_q      <= hpt_pkg::home_slot(mode_q, req_i.page_key, req_i.asid);
      probes_q <= '0;
    end else if (cmd_i.step) begin
      s_q      <= s_q + 1'b1;
      probes_q <= probes_q + 1'b1;
      if (stat_rd_q == hpt_pkg::ST_TOMB && !free_found_q) begin
        free_q <= s_q;
      end
    end
    if (div_done) begin
      vict_q <= home_q + div_rem[IW-1:0];
    end
    if (cmd_i.res_we) begin
      res_oc_q     <= cmd_i.res_code;
      res_data_q   <= cmd_i.res_data ? ent_rd_q[hpt_pkg::DATA_W-1:0] : '0;
      res_slot_q   <= res_slot;
      res_probes_q <= probes_q;
    end
    if (cmd_i.out_load) begin
      rsp_o.outcome     <= res_oc_q;
      rsp_o.hit_data    <= res_data_q;
      rsp_o.slot_index  <= res_slot_q;
      rsp_o.probe_count <= res_probes_q;
    end
  end

  // Remainder of the fresh LFSR value by the probe run length.
  hpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (lfsr_d),
    .divisor_i  (probes_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Status toward the controller.
  always_comb begin
    sts_o.rd_stat     = stat_rd_q;
    sts_o.match       = ent_rd_q[hpt_pkg::ENT_W-1:hpt_pkg::DATA_W] == {key_q, asid_q};
    sts_o.probes_max  = probes_q == CW'(N);
    sts_o.probes_zero = probes_q == '0;
    sts_o.op          = op_q;
    sts_o.live_lt     = live_q < limit_q;
    sts_o.free_found  = free_found_q;
    sts_o.clr_last    = clr_q == IW'(N - 1);
    sts_o.div_done    = div_done;
    sts_o.out_free    = !out_valid_q || rsp_o.ready;
  end

  assign rsp_o.valid = out_valid_q;

endmodule

// ===== hw/rtl/hpt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for clearing, search, insert, replace and erase.
module hpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hpt_pkg::sts_t sts_i,
  output hpt_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_VRD  = 3'd5;
  localparam logic [2:0] S_VEV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        state_d = S_FIN;
        if (sts_i.rd_stat != hpt_pkg::ST_EMPTY && !sts_i.probes_max) begin
          if (sts_i.rd_stat == hpt_pkg::ST_VALID && sts_i.match) begin
            cmd_o.res_we   = 1'b1;
            cmd_o.res_sel  = hpt_pkg::SEL_S;
            cmd_o.res_data = 1'b1;
            if (sts_i.op == hpt_pkg::OP_ERASE) begin
              cmd_o.st_we    = 1'b1;
              cmd_o.st_val   = hpt_pkg::ST_TOMB;
              cmd_o.wsel     = hpt_pkg::SEL_S;
              cmd_o.live_dec = 1'b1;
              cmd_o.res_code = hpt_pkg::OC_ERASED;
            end else begin
              cmd_o.res_code = hpt_pkg::OC_HIT;
            end
          end else begin
            cmd_o.step = 1'b1;
            state_d    = S_RD;
          end
        end else if (sts_i.op == hpt_pkg::OP_ERASE) begin
          cmd_o.res_we   = 1'b1;
          cmd_o.res_code = hpt_pkg::OC_NOTFOUND;
          cmd_o.res_sel  = hpt_pkg::SEL_ZERO;
        end else if (sts_i.live_lt) begin
          cmd_o.res_we = 1'b1;
          if (sts_i.free_found || !sts_i.probes_max) begin
            // First tombstone of the run, else the empty slot that ended it.
            cmd_o.wsel     = sts_i.free_found ? hpt_pkg::SEL_FREE : hpt_pkg::SEL_S;
            cmd_o.st_we    = 1'b1;
            cmd_o.st_val   = hpt_pkg::ST_VALID;
            cmd_o.ent_we   = 1'b1;
            cmd_o.live_inc = 1'b1;
            cmd_o.res_code = hpt_pkg::OC_INSERTED;
            cmd_o.res_sel  = cmd_o.wsel;
          end else begin
            cmd_o.res_code = hpt_pkg::OC_FULL;
            cmd_o.res_sel  = hpt_pkg::SEL_HOME;
          end
        end else if (sts_i.probes_zero) begin
          // Empty home slot: nothing to replace.
          cmd_o.res_we   = 1'b1;
          cmd_o.res_code = hpt_pkg::OC_REPFAIL;
          cmd_o.res_sel  = hpt_pkg::SEL_HOME;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        cmd_o.vict_rd = 1'b1;
        state_d       = S_VEV;
      end
      S_VEV: begin
        cmd_o.res_we  = 1'b1;
        cmd_o.res_sel = hpt_pkg::SEL_VICT;
        if (sts_i.rd_stat == hpt_pkg::ST_VALID) begin
          cmd_o.wsel     = hpt_pkg::SEL_VICT;
          cmd_o.ent_we   = 1'b1;
          cmd_o.res_code = hpt_pkg::OC_REPLACED;
        end else begin
          cmd_o.res_code = hpt_pkg::OC_REPFAIL;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/hashed_page_table_probe.sv =====
`timescale 1ns / 1ps
// Hashed page table with linear probing, 4096 slots.
// The request channel carries an operation (access or erase), a 52-bit page key,
// an ASID and fill data; the response channel returns one transaction per request
// with the outcome, hit data, slot index and extra probe count.
// Configuration (hash mode, occupancy limit) is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle.
// After reset the block sweeps the status memory, one slot per cycle, over all 4096
// slots; no request is accepted during that pass.
// One request is worked on at a time. Each probe of the search passes through a
// memory read state and an evaluation state. A replace then adds a remainder
// computation in the divider and a victim read with its own evaluation. The finish
// state loads the response into the output register as soon as that register is free.
// The response sits in an output register; a new request is accepted while it
// waits. A stalled receiver holds the response, and the next finished request
// waits in the sequencer until the output register frees up.
module hashed_page_table_probe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hpt_req_if.sink                          req_i,
  hpt_rsp_if.source                        rsp_o
);

  hpt_pkg::cmd_t cmd;
  hpt_pkg::sts_t sts;
  logic          in_ready;

  hpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .rsp_o      (rsp_o)
  );

  assign req_i.ready = in_ready;

endmodule

// ===== hw/rtl/hpt_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks of the response channel.
module hpt_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [hpt_pkg::OC_W-1:0]          outcome,
  input logic [hpt_pkg::DATA_W-1:0]        hit_data,
  input logic [hpt_pkg::IDX_W-1:0]         slot_index,
  input logic [hpt_pkg::CNT_W-1:0]         probe_count
);

  // Only hits and erases report stored data.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && outcome != hpt_pkg::OC_HIT && outcome != hpt_pkg::OC_ERASED
    |-> hit_data == '0) else $error("nonzero data on a non-hit outcome");

  // A failed erase reports slot zero.
  a_nf_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && outcome == hpt_pkg::OC_NOTFOUND |-> slot_index == '0)
    else $error("erase miss with nonzero slot");

  // The search never probes past the whole table.
  a_probe_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> probe_count <= hpt_pkg::CNT_W'(hpt_pkg::TABLE_ENTRIES))
    else $error("probe count beyond table size");

  // A full table is only seen after probing every slot.
  a_full_probes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && outcome == hpt_pkg::OC_FULL
    |-> probe_count == hpt_pkg::CNT_W'(hpt_pkg::TABLE_ENTRIES))
    else $error("table full before a complete search");

  // A stalled response holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome) && $stable(slot_index))
    else $error("response changed while stalled");

endmodule

bind hashed_page_table_probe hpt_chk u_hpt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .outcome     (rsp_o.outcome),
  .hit_data    (rsp_o.hit_data),
  .slot_index  (rsp_o.slot_index),
  .probe_count (rsp_o.probe_count)
);

// ===== verif/hashed_page_table_probe_test.sv =====
`timescale 1ns / 1ps
module hashed_page_table_probe_test;

  localparam int unsigned RUN_LIMIT    = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned PHASES       = 6;

  // One response transaction as the checker sees it.
  typedef struct packed {
    logic [hpt_pkg::OC_W-1:0]          outcome;
    logic signed [hpt_pkg::DATA_W-1:0] hit_data;
    logic [hpt_pkg::IDX_W-1:0]         slot_index;
    logic [hpt_pkg::CNT_W-1:0]         probe_count;
  } probe_rsp_t;

  // One row of the directed stimulus: a register write or a request.
  typedef struct {
    logic                           is_cfg;
    logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [hpt_pkg::CFG_DATA_W-1:0] cfg_val;
    logic                           op;
    logic [hpt_pkg::KEY_W-1:0]      key;
    logic [hpt_pkg::ASID_W-1:0]     asid;
    logic [hpt_pkg::DATA_W-1:0]     data;
    logic                           typed;
    probe_rsp_t                     exp;
  } probe_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  hpt_req_if req_if ();
  hpt_rsp_if rsp_if ();

  hashed_page_table_probe u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the table and its registers.
  logic [1:0]                 tbl_status [hpt_pkg::TABLE_ENTRIES];
  logic [hpt_pkg::KEY_W-1:0]  tbl_key    [hpt_pkg::TABLE_ENTRIES];
  logic [hpt_pkg::ASID_W-1:0] tbl_asid   [hpt_pkg::TABLE_ENTRIES];
  logic [hpt_pkg::DATA_W-1:0] tbl_data   [hpt_pkg::TABLE_ENTRIES];
  int unsigned                tbl_live;
  logic [hpt_pkg::LFSR_W-1:0] tbl_lfsr;
  logic [hpt_pkg::MODE_W-1:0] tbl_mode;
  int unsigned                tbl_limit;

  probe_rsp_t  pending_results[$];
  probe_row_t  directed_rows[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned outcome_seen [8];
  logic        long_hold_done;
  int unsigned hold_left;
  logic [7:0]  ready_pattern;
  int unsigned pattern_age;
  logic [hpt_pkg::KEY_W-1:0]  key_pool  [48];
  logic [hpt_pkg::ASID_W-1:0] asid_pool [4];

  // Home slot under the current hash mode.
  function automatic int unsigned home_of(logic [hpt_pkg::KEY_W-1:0] key,
                                          logic [hpt_pkg::ASID_W-1:0] asid);
    logic [hpt_pkg::FOLD_W-1:0] ext;
    logic [hpt_pkg::IDX_W-1:0]  acc;
    logic [hpt_pkg::KEY_W-1:0]  mix;
    ext = '0;
    ext[hpt_pkg::KEY_W-1:0] = key;
    acc = '0;
    mix = key ^ {{(hpt_pkg::KEY_W-hpt_pkg::ASID_W){1'b0}}, asid};
    if (tbl_mode == hpt_pkg::MODE_KEY) return key[hpt_pkg::IDX_W-1:0];
    if (tbl_mode == hpt_pkg::MODE_ASID) return mix[hpt_pkg::IDX_W-1:0];
    for (int i = 0; i < hpt_pkg::FOLD_CNT; i++) begin
      acc ^= ext[i*hpt_pkg::IDX_W +: hpt_pkg::IDX_W];
    end
    return acc;
  endfunction

  // Works out the response of one request and updates the shadow table.
  function automatic probe_rsp_t predict_probe(logic op, logic [hpt_pkg::KEY_W-1:0] key,
                                               logic [hpt_pkg::ASID_W-1:0] asid,
                                               logic [hpt_pkg::DATA_W-1:0] data);
    probe_rsp_t  res;
    int unsigned home;
    int unsigned s;
    int unsigned probes;
    int unsigned run_len;
    int unsigned victim;
    res = '0;
    home = home_of(key, asid);
    s = home;
    probes = 0;
    // Search past tombstones until a match or an empty slot.
    while (tbl_status[s] != hpt_pkg::ST_EMPTY && probes < hpt_pkg::TABLE_ENTRIES) begin
      if (tbl_status[s] == hpt_pkg::ST_VALID && tbl_key[s] == key && tbl_asid[s] == asid) begin
        res.hit_data = tbl_data[s];
        res.slot_index = hpt_pkg::IDX_W'(s);
        res.probe_count = hpt_pkg::CNT_W'(probes);
        if (op == hpt_pkg::OP_ERASE) begin
          tbl_status[s] = hpt_pkg::ST_TOMB;
          if (tbl_live > 0) tbl_live--;
          res.outcome = hpt_pkg::OC_ERASED;
        end else begin
          res.outcome = hpt_pkg::OC_HIT;
        end
        return res;
      end
      s = (s + 1) % hpt_pkg::TABLE_ENTRIES;
      probes++;
    end
    res.probe_count = hpt_pkg::CNT_W'(probes);
    if (op == hpt_pkg::OP_ERASE) begin
      res.outcome = hpt_pkg::OC_NOTFOUND;
      return res;
    end
    // Insert into the first slot that holds no live entry.
    if (tbl_live < tbl_limit) begin
      s = home;
      for (int k = 0; k < hpt_pkg::TABLE_ENTRIES; k++) begin
        if (tbl_status[s] != hpt_pkg::ST_VALID) begin
          tbl_status[s] = hpt_pkg::ST_VALID;
          tbl_key[s] = key;
          tbl_asid[s] = asid;
          tbl_data[s] = data;
          tbl_live = (tbl_live + 1) & 13'h1FFF;
          res.outcome = hpt_pkg::OC_INSERTED;
          res.slot_index = hpt_pkg::IDX_W'(s);
          return res;
        end
        s = (s + 1) % hpt_pkg::TABLE_ENTRIES;
      end
      res.outcome = hpt_pkg::OC_FULL;
      res.slot_index = hpt_pkg::IDX_W'(home);
      return res;
    end
    // Replace a random slot of the run that starts at home.
    if (tbl_status[home] == hpt_pkg::ST_EMPTY) begin
      res.outcome = hpt_pkg::OC_REPFAIL;
      res.slot_index = hpt_pkg::IDX_W'(home);
      return res;
    end
    s = home;
    run_len = 0;
    while (tbl_status[s] != hpt_pkg::ST_EMPTY && run_len < hpt_pkg::TABLE_ENTRIES) begin
      run_len++;
      s = (s + 1) % hpt_pkg::TABLE_ENTRIES;
    end
    tbl_lfsr = tbl_lfsr[0] ? ((tbl_lfsr >> 1) ^ hpt_pkg::LFSR_TAPS) : (tbl_lfsr >> 1);
    victim = (home + (tbl_lfsr % run_len)) % hpt_pkg::TABLE_ENTRIES;
    res.slot_index = hpt_pkg::IDX_W'(victim);
    if (tbl_status[victim] != hpt_pkg::ST_VALID) begin
      res.outcome = hpt_pkg::OC_REPFAIL;
      return res;
    end
    tbl_key[victim] = key;
    tbl_asid[victim] = asid;
    tbl_data[victim] = data;
    res.outcome = hpt_pkg::OC_REPLACED;
    return res;
  endfunction

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("FAIL hashed_page_table_probe");
      $finish;
    end
  end

  // Receiver: a rotating ready pattern, plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
      ready_pattern <= 8'hFF;
      pattern_age <= 0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 400) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 600;
      long_hold_done <= 1'b1;
    end else begin
      rsp_if.ready <= ready_pattern[0];
      pattern_age <= pattern_age + 1;
      if (pattern_age % 64 == 63) begin
        case ($urandom_range(0, 3))
          0, 1:    ready_pattern <= 8'hFF;
          2:       ready_pattern <= 8'($urandom) | 8'h01;
          default: ready_pattern <= 8'h11;
        endcase
      end else begin
        ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
      end
    end
  end

  // Response checker: a transaction completes at the edge after a sampled handshake.
  always @(negedge clk_i) begin
    probe_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen <= results_seen + 1;
      outcome_seen[rsp_if.outcome] <= outcome_seen[rsp_if.outcome] + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected response: outcome %0d slot %0d", rsp_if.outcome,
               rsp_if.slot_index);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, rsp_if.outcome);
          errors++;
        end
        if (rsp_if.hit_data !== want.hit_data) begin
          $error("hit_data: expected %0d, got %0d", want.hit_data, rsp_if.hit_data);
          errors++;
        end
        if (rsp_if.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_if.slot_index);
          errors++;
        end
        if (rsp_if.probe_count !== want.probe_count) begin
          $error("probe_count: expected %0d, got %0d", want.probe_count,
                 rsp_if.probe_count);
          errors++;
        end
      end
    end
  end

  // Offers one request from a rising edge and returns at the edge that accepts it.
  task automatic send_request(logic op, logic [hpt_pkg::KEY_W-1:0] key,
                              logic [hpt_pkg::ASID_W-1:0] asid,
                              logic [hpt_pkg::DATA_W-1:0] data, logic typed,
                              probe_rsp_t typed_rsp);
    probe_rsp_t predicted;
    logic       taken;
    predicted = predict_probe(op, key, asid, data);
    pending_results.push_back(typed ? typed_rsp : predicted);
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.page_key <= key;
    req_if.asid <= asid;
    req_if.fill_data <= data;
    items_sent++;
    forever begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  // Drops valid, waits until every response is back, then writes a register.
  task automatic write_register(logic [hpt_pkg::CFG_IDX_W-1:0] idx,
                                logic [hpt_pkg::CFG_DATA_W-1:0] val);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hpt_pkg::REG_SCRAMBLE) tbl_mode = val[hpt_pkg::MODE_W-1:0];
    else tbl_limit = val;
  endtask

  function automatic void add_write(logic [hpt_pkg::CFG_IDX_W-1:0] idx,
                                    logic [hpt_pkg::CFG_DATA_W-1:0] val);
    probe_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_request(logic op, logic [hpt_pkg::KEY_W-1:0] key,
                                      logic [hpt_pkg::ASID_W-1:0] asid,
                                      logic [hpt_pkg::DATA_W-1:0] data, logic typed,
                                      logic [hpt_pkg::OC_W-1:0] oc,
                                      logic [hpt_pkg::DATA_W-1:0] hd,
                                      logic [hpt_pkg::IDX_W-1:0] slot,
                                      logic [hpt_pkg::CNT_W-1:0] pr);
    probe_row_t row;
    row = '{default: '0};
    row.op = op;
    row.key = key;
    row.asid = asid;
    row.data = data;
    row.typed = typed;
    row.exp = '{outcome: oc, hit_data: hd, slot_index: slot, probe_count: pr};
    directed_rows.push_back(row);
  endfunction

  initial begin
    probe_row_t                 row;
    int unsigned                burst_left;
    logic                       steady;
    logic [hpt_pkg::KEY_W-1:0]  key;
    logic [hpt_pkg::ASID_W-1:0] asid;
    logic                       op;

    req_if.valid = 1'b0;
    req_if.operation = hpt_pkg::OP_ACCESS;
    req_if.page_key = '0;
    req_if.asid = '0;
    req_if.fill_data = '0;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    items_sent = 0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;
    foreach (tbl_status[i]) tbl_status[i] = hpt_pkg::ST_EMPTY;
    tbl_live = 0;
    tbl_lfsr = hpt_pkg::LFSR_SEED;
    tbl_mode = hpt_pkg::MODE_KEY;
    tbl_limit = hpt_pkg::TABLE_ENTRIES;

    // Directed table: first the plain hash, then replacement, then the other hashes.
    add_request(hpt_pkg::OP_ACCESS, '0, '0, 32'h7FFFFFFF, 1, hpt_pkg::OC_INSERTED, 0, 0, 0);
    add_request(hpt_pkg::OP_ACCESS, '0, '0, 32'h1, 1, hpt_pkg::OC_HIT, 32'h7FFFFFFF, 0, 0);
    add_request(hpt_pkg::OP_ACCESS, '1, '1, 32'h80000000, 1, hpt_pkg::OC_INSERTED, 0,
                12'hFFF, 0);
    add_request(hpt_pkg::OP_ACCESS, '1, '1, 32'h2, 1, hpt_pkg::OC_HIT, 32'h80000000,
                12'hFFF, 0);
    add_request(hpt_pkg::OP_ACCESS, 52'd4096, '0, 32'd5, 1, hpt_pkg::OC_INSERTED, 0, 1, 1);
    add_request(hpt_pkg::OP_ERASE, '0, '0, 32'd0, 1, hpt_pkg::OC_ERASED, 32'h7FFFFFFF, 0, 0);
    add_request(hpt_pkg::OP_ERASE, '0, '0, 32'd0, 1, hpt_pkg::OC_NOTFOUND, 0, 0, 2);
    add_request(hpt_pkg::OP_ACCESS, 52'd4096, '0, 32'd9, 1, hpt_pkg::OC_HIT, 32'd5, 1, 1);
    add_request(hpt_pkg::OP_ACCESS, 52'd8192, '0, 32'd7, 1, hpt_pkg::OC_INSERTED, 0, 0, 2);
    add_request(hpt_pkg::OP_ERASE, 52'd12345, 16'd3, 32'd0, 1, hpt_pkg::OC_NOTFOUND,
                0, 0, 0);
    add_write(hpt_pkg::REG_LIMIT, '0);
    add_request(hpt_pkg::OP_ACCESS, 52'd99, '0, 32'd11, 1, hpt_pkg::OC_REPFAIL, 0, 99, 0);
    add_request(hpt_pkg::OP_ACCESS, 52'd4097, '0, 32'd12, 1, hpt_pkg::OC_REPLACED,
                0, 1, 1);
    add_request(hpt_pkg::OP_ACCESS, '0, '0, 32'd13, 0, 0, 0, 0, 0);
    add_request(hpt_pkg::OP_ACCESS, 52'd3, 16'h5, 32'hDEADBEEF, 0, 0, 0, 0, 0);
    add_write(hpt_pkg::REG_LIMIT, 13'h1FFF);
    add_write(hpt_pkg::REG_SCRAMBLE, hpt_pkg::MODE_ASID);
    add_request(hpt_pkg::OP_ACCESS, 52'h12345, 16'h00FF, 32'h5A5A5A5A, 0, 0, 0, 0, 0);
    add_request(hpt_pkg::OP_ACCESS, 52'h12345, 16'h00FF, 32'h0, 0, 0, 0, 0, 0);
    add_request(hpt_pkg::OP_ACCESS, 52'h123BA, 16'h0000, 32'h3, 0, 0, 0, 0, 0);
    add_write(hpt_pkg::REG_SCRAMBLE, 2'd2);
    add_request(hpt_pkg::OP_ACCESS, 52'hABCDE_F0123_456, 16'h1, 32'h4, 0, 0, 0, 0, 0);
    add_request(hpt_pkg::OP_ERASE, 52'hABCDE_F0123_456, 16'h1, 32'h0, 0, 0, 0, 0, 0);
    add_write(hpt_pkg::REG_SCRAMBLE, 2'd3);
    add_request(hpt_pkg::OP_ACCESS, 52'h00FFF_FFF00_0FF, 16'hFFFF, 32'h6, 0, 0, 0, 0, 0);
    add_write(hpt_pkg::REG_LIMIT, hpt_pkg::CFG_DATA_W'(hpt_pkg::TABLE_ENTRIES));

    // Keys that collide often, so hits, erases and probe runs are common.
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      if (i % 2 == 0) begin
        key_pool[i][hpt_pkg::IDX_W-1:0] = hpt_pkg::IDX_W'($urandom_range(0, 63));
      end
    end
    asid_pool[0] = '0;
    asid_pool[1] = '1;
    asid_pool[2] = 16'($urandom);
    asid_pool[3] = 16'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_register(row.cfg_idx, row.cfg_val);
      else send_request(row.op, row.key, row.asid, row.data, row.typed, row.exp);
    end

    // Random phases, each under its own hash mode and occupancy limit.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_register(hpt_pkg::REG_SCRAMBLE, hpt_pkg::CFG_DATA_W'($urandom_range(0, 3)));
      case ($urandom_range(0, 4))
        0:       write_register(hpt_pkg::REG_LIMIT, '0);
        1:       write_register(hpt_pkg::REG_LIMIT, 13'h1FFF);
        2:       write_register(hpt_pkg::REG_LIMIT,
                                hpt_pkg::CFG_DATA_W'(hpt_pkg::TABLE_ENTRIES));
        3:       write_register(hpt_pkg::REG_LIMIT,
                                hpt_pkg::CFG_DATA_W'(tbl_live + $urandom_range(0, 8)));
        default: write_register(hpt_pkg::REG_LIMIT,
                                hpt_pkg::CFG_DATA_W'($urandom_range(1, 300)));
      endcase
      burst_left = 0;
      steady = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (burst_left == 0) begin
          steady = ($urandom_range(0, 3) == 0);
          burst_left = $urandom_range(1, 20);
          if (!steady) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk_i);
          end
        end
        burst_left--;
        if ($urandom_range(0, 99) < 85) begin
          key = key_pool[$urandom_range(0, 47)];
          asid = asid_pool[$urandom_range(0, 3)];
        end else begin
          key = {$urandom, $urandom};
          asid = 16'($urandom);
        end
        op = ($urandom_range(0, 3) == 0) ? hpt_pkg::OP_ERASE : hpt_pkg::OP_ACCESS;
        send_request(op, key, asid, $urandom, 1'b0, '0);
      end
    end
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests: %0d hits, %0d inserts, %0d replaces, %0d failed replaces,",
             items_sent, outcome_seen[hpt_pkg::OC_HIT], outcome_seen[hpt_pkg::OC_INSERTED],
             outcome_seen[hpt_pkg::OC_REPLACED], outcome_seen[hpt_pkg::OC_REPFAIL]);
    $display("  %0d erases, %0d erase misses, %0d full-table results, %0d mismatches.",
             outcome_seen[hpt_pkg::OC_ERASED], outcome_seen[hpt_pkg::OC_NOTFOUND],
             outcome_seen[hpt_pkg::OC_FULL], errors);
    if (errors == 0) begin
      $display("PASS hashed_page_table_probe");
    end else begin
      $display("FAIL hashed_page_table_probe");
    end
    $finish;
  end

endmodule
